@@ rtl/packed_sample_to_rgb_pixels_assert.svh @@
// Assertion macros shared by the RTL of the packed sample unpacker.
`ifndef PACKED_SAMPLE_TO_RGB_PIXELS_ASSERT_SVH
`define PACKED_SAMPLE_TO_RGB_PIXELS_ASSERT_SVH

// Checks that a property holds at every clock edge outside of reset.
`define PS2RGB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition never occurs outside of reset.
`define PS2RGB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/ps2rgb_pkg.sv @@
`default_nettype none

package ps2rgb_pkg;

  // Image size limits.
  localparam int MAX_WIDTH  = 8192;
  localparam int MAX_HEIGHT = 8192;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // Queue sizes.
  localparam int IN_DEPTH    = 2;
  localparam int IN_PTR_W    = $clog2(IN_DEPTH);
  localparam int IN_LEVEL_W  = $clog2(IN_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
  localparam int OUT_LEVEL_W = $clog2(OUT_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLOR_MODE   = 2'd0;
  localparam logic [1:0] CFG_BPC          = 2'd1;
  localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd3;

  // Color mode codes.
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;
  localparam logic [1:0] MODE_CMYK = 2'd2;

  // Sample width codes.
  typedef enum logic [1:0] {
    SW_1,
    SW_2,
    SW_4,
    SW_8
  } samp_width_e;

  // One raw byte with its sample width, as handed from front to back.
  typedef struct packed {
    logic [7:0]  data;
    samp_width_e width;
  } byte_item_t;

  // One finished pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
  } pixel_t;

  // Maps the bits-per-component register onto a sample width.
  function automatic samp_width_e decode_width(input logic [3:0] bpc);
    samp_width_e w;
    unique case (bpc)
      4'd1:    w = SW_1;
      4'd2:    w = SW_2;
      4'd4:    w = SW_4;
      default: w = SW_8;
    endcase
    return w;
  endfunction

  // Index of the last sample in a byte.
  function automatic logic [2:0] last_sample(input samp_width_e w);
    logic [2:0] n;
    unique case (w)
      SW_1:    n = 3'd7;
      SW_2:    n = 3'd3;
      SW_4:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  // Scales the top sample of a byte to 8 bits by bit replication.
  function automatic logic [7:0] expand_sample(input logic [7:0] d, input samp_width_e w);
    logic [7:0] s;
    unique case (w)
      SW_1:    s = {8{d[7]}};
      SW_2:    s = {4{d[7:6]}};
      SW_4:    s = {2{d[7:4]}};
      default: s = d;
    endcase
    return s;
  endfunction

  // Moves the next sample of a byte to the top.
  function automatic logic [7:0] shift_sample(input logic [7:0] d, input samp_width_e w);
    logic [7:0] s;
    unique case (w)
      SW_1:    s = {d[6:0], 1'b0};
      SW_2:    s = {d[5:0], 2'b0};
      SW_4:    s = {d[3:0], 4'b0};
      default: s = 8'd0;
    endcase
    return s;
  endfunction

  // Last column or row index; zero acts as one and oversize saturates.
  function automatic logic [12:0] last_index(input logic [13:0] v, input logic [13:0] limit);
    logic [13:0] m;
    if (v == 14'd0) begin
      m = 14'd0;
    end else if (v > limit) begin
      m = limit - 14'd1;
    end else begin
      m = v - 14'd1;
    end
    return m[12:0];
  endfunction

  // Exact floor(p / 255) for p up to 255 * 255.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] t;
    t = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

`default_nettype wire

@@ rtl/ps2rgb_front.sv @@
`default_nettype none

module ps2rgb_front import ps2rgb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [3:0]  bpc_i,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte_i,
  output      byte_item_t  item_o,
  output      logic        valid_o,
  input  wire logic        pop_i
);

  byte_item_t              mem_q [IN_DEPTH];
  logic [IN_PTR_W-1:0]     wr_ptr_q, rd_ptr_q;
  logic [IN_LEVEL_W-1:0]   level_q, level_d;
  logic                    do_push, do_pop;

  assign full    = (level_q == IN_LEVEL_W'(IN_DEPTH));
  assign valid_o = (level_q != '0);
  assign do_push = push && !full;
  assign do_pop  = pop_i && valid_o;
  assign item_o  = mem_q[rd_ptr_q];

  // Occupancy follows the push and pop transactions.
  always_comb begin
    level_d = level_q;
    if (do_push && !do_pop) begin
      level_d = level_q + IN_LEVEL_W'(1);
    end else if (!do_push && do_pop) begin
      level_d = level_q - IN_LEVEL_W'(1);
    end
  end

  // Each accepted byte is tagged with its sample width on the way in.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= '{data: data_byte_i, width: decode_width(bpc_i)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + IN_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + IN_PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ps2rgb_back.sv @@
`default_nettype none

module ps2rgb_back import ps2rgb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [1:0]             color_mode_i,
  input  wire logic [COL_W-1:0]       col_last_i,
  input  wire logic [ROW_W-1:0]       row_last_i,
  input  wire byte_item_t             q_item_i,
  input  wire logic                   q_valid_i,
  output      logic                   q_pop_o,
  input  wire logic [OUT_LEVEL_W-1:0] out_level_i,
  output      pixel_t                 pix_o,
  output      logic                   pix_we_o
);

  // Current byte being cut into samples.
  logic [7:0]       cur_q, cur_d;
  samp_width_e      cur_w_q, cur_w_d;
  logic [2:0]       rem_q, rem_d;
  logic             cur_v_q, cur_v_d;

  // Pixel assembly and position state.
  logic [23:0]      pend_q, pend_d;
  logic [1:0]       cnt_q, cnt_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             done_q, done_d;

  // Product stage.
  logic             s1_v_q;
  logic             s1_cmyk_q;
  logic [15:0]      s1_r_q, s1_g_q, s1_b_q;
  logic             s1_row_end_q, s1_image_end_q;
  logic [15:0]      s1_r_d, s1_g_d, s1_b_d;

  logic [7:0]       samp;
  logic [2:0]       group;
  logic             is_cmyk;
  logic             credit_ok, step, work, complete, emit;
  logic             row_end, image_end, byte_done, load;

  assign samp      = expand_sample(cur_q, cur_w_q);
  assign credit_ok = ({1'b0, out_level_i} + (OUT_LEVEL_W + 1)'(s1_v_q))
                     < (OUT_LEVEL_W + 1)'(OUT_DEPTH);
  assign step      = cur_v_q && (done_q || credit_ok);
  assign work      = step && !done_q;
  assign complete  = ({1'b0, cnt_q} + 3'd1) >= group;
  assign emit      = work && complete;
  assign row_end   = (col_q >= col_last_i);
  assign image_end = row_end && (row_q >= row_last_i);
  assign byte_done = done_q || (rem_q == 3'd0) || (emit && row_end);
  assign load      = !cur_v_q || (step && byte_done);
  assign q_pop_o   = load && q_valid_i;
  assign is_cmyk   = (color_mode_i == MODE_CMYK);

  // Samples per pixel for the current color mode.
  always_comb begin
    unique case (color_mode_i)
      MODE_RGB:  group = 3'd3;
      MODE_CMYK: group = 3'd4;
      default:   group = 3'd1;
    endcase
  end

  // Channel values ahead of the product register; CMYK gets (255-X)*(255-K).
  always_comb begin
    if (is_cmyk) begin
      s1_r_d = {8'h00, ~pend_q[23:16]} * {8'h00, ~samp};
      s1_g_d = {8'h00, ~pend_q[15:8]}  * {8'h00, ~samp};
      s1_b_d = {8'h00, ~pend_q[7:0]}   * {8'h00, ~samp};
    end else if (group == 3'd3) begin
      s1_r_d = {8'h00, pend_q[15:8]};
      s1_g_d = {8'h00, pend_q[7:0]};
      s1_b_d = {8'h00, samp};
    end else begin
      s1_r_d = {8'h00, samp};
      s1_g_d = {8'h00, samp};
      s1_b_d = {8'h00, samp};
    end
  end

  // Sample walk, pixel grouping and row and column tracking.
  always_comb begin
    cur_d   = cur_q;
    cur_w_d = cur_w_q;
    rem_d   = rem_q;
    cur_v_d = cur_v_q;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    col_d   = col_q;
    row_d   = row_q;
    done_d  = done_q;

    if (work) begin
      if (!complete) begin
        pend_d = {pend_q[15:0], samp};
        cnt_d  = cnt_q + 2'd1;
      end else begin
        pend_d = '0;
        cnt_d  = '0;
        if (row_end) begin
          col_d = '0;
          if (image_end) begin
            row_d  = '0;
            done_d = 1'b1;
          end else begin
            row_d = row_q + ROW_W'(1);
          end
        end else begin
          col_d = col_q + COL_W'(1);
        end
      end
    end

    if (step && !byte_done) begin
      cur_d = shift_sample(cur_q, cur_w_q);
      rem_d = rem_q - 3'd1;
    end

    if (load) begin
      cur_v_d = q_valid_i;
      cur_d   = q_item_i.data;
      cur_w_d = q_item_i.width;
      rem_d   = last_sample(q_item_i.width);
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q   <= cur_d;
    cur_w_q <= cur_w_d;
    rem_q   <= rem_d;
    if (emit) begin
      s1_cmyk_q      <= is_cmyk;
      s1_r_q         <= s1_r_d;
      s1_g_q         <= s1_g_d;
      s1_b_q         <= s1_b_d;
      s1_row_end_q   <= row_end;
      s1_image_end_q <= image_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q <= 1'b0;
      pend_q  <= '0;
      cnt_q   <= '0;
      col_q   <= '0;
      row_q   <= '0;
      done_q  <= 1'b0;
      s1_v_q  <= 1'b0;
    end else begin
      cur_v_q <= cur_v_d;
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      col_q   <= col_d;
      row_q   <= row_d;
      done_q  <= done_d;
      s1_v_q  <= emit;
    end
  end

  // Division by 255 for CMYK after the product register, then into the result queue.
  assign pix_we_o        = s1_v_q;
  assign pix_o.red       = s1_cmyk_q ? div255(s1_r_q) : s1_r_q[7:0];
  assign pix_o.green     = s1_cmyk_q ? div255(s1_g_q) : s1_g_q[7:0];
  assign pix_o.blue      = s1_cmyk_q ? div255(s1_b_q) : s1_b_q[7:0];
  assign pix_o.row_end   = s1_row_end_q;
  assign pix_o.image_end = s1_image_end_q;

endmodule

`default_nettype wire

@@ rtl/ps2rgb_ofifo.sv @@
`default_nettype none

module ps2rgb_ofifo import ps2rgb_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   wr_i,
  input  wire pixel_t                 pix_i,
  input  wire logic                   pop,
  output      logic                   empty,
  output      logic [OUT_LEVEL_W-1:0] level_o,
  output      pixel_t                 pix_o
);

  pixel_t                 mem_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [OUT_LEVEL_W-1:0] level_q, level_d;
  logic                   do_pop;

  assign empty   = (level_q == '0);
  assign level_o = level_q;
  assign do_pop  = pop && !empty;
  assign pix_o   = mem_q[rd_ptr_q];

  // Occupancy follows writes from the back end and pop transactions.
  always_comb begin
    level_d = level_q;
    if (wr_i && !do_pop) begin
      level_d = level_q + OUT_LEVEL_W'(1);
    end else if (!wr_i && do_pop) begin
      level_d = level_q - OUT_LEVEL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= pix_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      level_q <= level_d;
      if (wr_i) begin
        wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/packed_sample_to_rgb_pixels.sv @@
// The back end takes one sample per cycle while the result queue has room; a byte holds 1, 2,
// 4 or 8 samples for 8, 4, 2 or 1 bits per component; at most one pixel leaves per cycle.
// A 2-entry byte queue and a 4-entry pixel queue let input and output stall independently.
// Reset (rst_ni low, asynchronous) empties both queues, restarts at row 0, column 0, and
// loads color_mode 1 (RGB), bits_per_component 8 and a 1 by 1 image.
`default_nettype none

module packed_sample_to_rgb_pixels import ps2rgb_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [13:0] cfg_data_i,
  input  wire logic        push,
  output      logic        full,
  input  wire logic [7:0]  data_byte_i,
  output      logic        empty,
  input  wire logic        pop,
  output      logic [7:0]  red_o,
  output      logic [7:0]  green_o,
  output      logic [7:0]  blue_o,
  output      logic        row_end_o,
  output      logic        image_end_o
);

`include "packed_sample_to_rgb_pixels_assert.svh"

  logic [1:0]             color_mode_q;
  logic [3:0]             bpc_q;
  logic [13:0]            width_q, height_q;
  logic [COL_W-1:0]       col_last;
  logic [ROW_W-1:0]       row_last;

  byte_item_t             q_item;
  logic                   q_valid, q_pop;
  logic [OUT_LEVEL_W-1:0] out_level;
  pixel_t                 pix_wr, pix_rd;
  logic                   pix_we;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q <= MODE_RGB;
      bpc_q        <= 4'd8;
      width_q      <= 14'd1;
      height_q     <= 14'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_COLOR_MODE:   color_mode_q <= cfg_data_i[1:0];
        CFG_BPC:          bpc_q        <= cfg_data_i[3:0];
        CFG_IMAGE_WIDTH:  width_q      <= cfg_data_i;
        CFG_IMAGE_HEIGHT: height_q     <= cfg_data_i;
        default:          color_mode_q <= color_mode_q;
      endcase
    end
  end

  // Last column and row after clamping the image size.
  assign col_last = COL_W'(last_index(width_q, 14'(MAX_WIDTH)));
  assign row_last = ROW_W'(last_index(height_q, 14'(MAX_HEIGHT)));

  ps2rgb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .bpc_i       (bpc_q),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte_i),
    .item_o      (q_item),
    .valid_o     (q_valid),
    .pop_i       (q_pop)
  );

  ps2rgb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .color_mode_i (color_mode_q),
    .col_last_i   (col_last),
    .row_last_i   (row_last),
    .q_item_i     (q_item),
    .q_valid_i    (q_valid),
    .q_pop_o      (q_pop),
    .out_level_i  (out_level),
    .pix_o        (pix_wr),
    .pix_we_o     (pix_we)
  );

  ps2rgb_ofifo u_ofifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (pix_we),
    .pix_i   (pix_wr),
    .pop     (pop),
    .empty   (empty),
    .level_o (out_level),
    .pix_o   (pix_rd)
  );

  assign red_o       = pix_rd.red;
  assign green_o     = pix_rd.green;
  assign blue_o      = pix_rd.blue;
  assign row_end_o   = pix_rd.row_end;
  assign image_end_o = pix_rd.image_end;

  // The back end must never write a pixel into a full result queue.
  `PS2RGB_NEVER(a_no_ofifo_overflow, pix_we && (out_level == OUT_LEVEL_W'(OUT_DEPTH)) && !(pop && !empty), "pixel written into a full result queue")
  // The back end only takes bytes that the front queue holds.
  `PS2RGB_ASSERT(a_pop_needs_byte, q_pop |-> q_valid, "byte queue popped while empty")
  // The last pixel of the image is always the last of its row.
  `PS2RGB_ASSERT(a_image_end_is_row_end, (!empty && image_end_o) |-> row_end_o, "image end without row end")

endmodule

`default_nettype wire
